@@ rtl/core/mexp_pkg.sv @@
package mexp_pkg;

	localparam int OPERAND_BITS = 63;
	localparam int CNT_W        = $clog2(OPERAND_BITS);
	localparam int CFG_IDX_W    = 1;

	typedef logic [OPERAND_BITS-1:0] operand_t;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODULUS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXPONENT = 1'b1;

	localparam operand_t OPERAND_ONE = operand_t'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} mexp_state_t;

endpackage

@@ rtl/core/mexp_mulmod.sv @@
module mexp_mulmod
	import mexp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  operand_t op_a,
	input  operand_t op_b,
	input  operand_t modulus,
	output logic     done,
	output operand_t product
);

	logic                  run_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	operand_t              acc_q;
	operand_t              a_q;
	operand_t              b_q;
	operand_t              m_q;

	logic [OPERAND_BITS:0] dbl;
	logic [OPERAND_BITS:0] dbl_red;
	logic [OPERAND_BITS:0] sum;
	logic [OPERAND_BITS:0] sum_red;
	operand_t              acc_d;

	// one msb-first shift-and-add step: acc = 2*acc + bit*a, reduced below m
	always_comb begin
		dbl = {acc_q, 1'b0};
		if (dbl >= {1'b0, m_q}) begin
			dbl_red = dbl - {1'b0, m_q};
		end else begin
			dbl_red = dbl;
		end
		sum = dbl_red + {1'b0, a_q};
		if (sum >= {1'b0, m_q}) begin
			sum_red = sum - {1'b0, m_q};
		end else begin
			sum_red = sum;
		end
		if (b_q[OPERAND_BITS-1]) begin
			acc_d = sum_red[OPERAND_BITS-1:0];
		end else begin
			acc_d = dbl_red[OPERAND_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(OPERAND_BITS - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= op_a;
			b_q   <= op_b;
			m_q   <= modulus;
		end else if (run_q) begin
			acc_q <= acc_d;
			b_q   <= {b_q[OPERAND_BITS-2:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ rtl/core/modular_exponentiation_unit.sv @@
// each item runs one reduction of the message, one multiplication per set exponent bit and
// one squaring per bit position below the highest set exponent bit; busy is high from the
// start edge through the done strobe, and a new item is taken only when idle, one at a time
// each modular multiplication is 63 shift-and-add steps of one shared unit, with a launch
// and a hand-back around them; trailing squarings past the top exponent bit are skipped
// arst_n clears the sequencer and sets modulus to 1, exponent to 0
// done is a one-cycle strobe with power_result valid; the receiver cannot stall
module modular_exponentiation_unit
	import mexp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  operand_t             cfg_wdata,
	input  logic                 start,
	input  operand_t             message_value,
	output logic                 busy,
	output logic                 done,
	output operand_t             power_result
);

	mexp_state_t state_q;
	mexp_state_t state_d;

	operand_t key_modulus_q;
	operand_t key_exponent_q;
	operand_t m_q;
	operand_t msg_q;
	operand_t exp_q;
	operand_t base_q;
	operand_t res_q;
	logic     go_q;

	operand_t m_eff;
	operand_t exp_next;
	logic     launch;
	operand_t mm_a;
	operand_t mm_b;
	logic     mm_done;
	operand_t mm_prod;

	// zero modulus is treated as one
	assign m_eff    = (key_modulus_q == '0) ? OPERAND_ONE : key_modulus_q;
	assign exp_next = {1'b0, exp_q[OPERAND_BITS-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_modulus_q  <= OPERAND_ONE;
			key_exponent_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				CFG_IDX_MODULUS:  key_modulus_q  <= cfg_wdata;
				CFG_IDX_EXPONENT: key_exponent_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mm_done) begin
					if (exp_q == '0) begin
						state_d = ST_DONE;
					end else if (exp_q[0]) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_SQR;
					end
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					state_d = (exp_next == '0) ? ST_DONE : ST_SQR;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					if (exp_next == '0) begin
						state_d = ST_DONE;
					end else if (exp_next[0]) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_SQR;
					end
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != ST_IDLE);
		done   = (state_q == ST_DONE);
		launch = 1'b0;
		mm_a   = '0;
		mm_b   = '0;
		case (state_q)
			ST_IDLE: begin
				launch = start;
			end
			ST_REDUCE: begin
				// msg mod m as 1 * msg mod m
				mm_a   = OPERAND_ONE;
				mm_b   = msg_q;
				launch = mm_done && (state_d != ST_DONE);
			end
			ST_MUL: begin
				mm_a   = res_q;
				mm_b   = base_q;
				launch = mm_done && (state_d != ST_DONE);
			end
			ST_SQR: begin
				mm_a   = base_q;
				mm_b   = base_q;
				launch = mm_done && (state_d != ST_DONE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= launch;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					m_q   <= m_eff;
					msg_q <= message_value;
					exp_q <= key_exponent_q;
					res_q <= (m_eff == OPERAND_ONE) ? '0 : OPERAND_ONE;
				end
			end
			ST_REDUCE: begin
				if (mm_done) begin
					base_q <= mm_prod;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					res_q <= mm_prod;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					base_q <= mm_prod;
					exp_q  <= exp_next;
				end
			end
			default: ;
		endcase
	end

	mexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (go_q),
		.op_a    (mm_a),
		.op_b    (mm_b),
		.modulus (m_q),
		.done    (mm_done),
		.product (mm_prod)
	);

	assign power_result = res_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import mexp_pkg::*;

	localparam int       RANDOM_ITEMS = 80;
	localparam int       CALM_ITEMS   = 20;
	localparam int       TAIL_CYCLES  = 8300;
	localparam int       STALL_LIMIT  = 40000;
	localparam operand_t TOP_VALUE    = '1;
	localparam operand_t MERSENNE_61  = (operand_t'(1) << 61) - operand_t'(1);

	class power_scoreboard;
		operand_t modulus;
		operand_t exponent;
		operand_t pending_powers[$];
		int       mismatches;

		function new();
			modulus = OPERAND_ONE;
			exponent = '0;
			mismatches = 0;
		endfunction

		function void set_key(logic [CFG_IDX_W-1:0] idx, operand_t value);
			if (idx == CFG_IDX_MODULUS) begin
				modulus = value;
			end else if (idx == CFG_IDX_EXPONENT) begin
				exponent = value;
			end
		endfunction

		// msb-first shift-and-add, all operands below m
		function logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
			logic [63:0] acc;
			int i;
			acc = '0;
			for (i = OPERAND_BITS - 1; i >= 0; i--) begin
				acc = acc << 1;
				if (acc >= m) begin
					acc = acc - m;
				end
				if (b[i]) begin
					acc = acc + a;
					if (acc >= m) begin
						acc = acc - m;
					end
				end
			end
			return acc;
		endfunction

		function operand_t expected_power(operand_t msg);
			logic [63:0] m;
			logic [63:0] base;
			logic [63:0] acc;
			int i;
			m = 64'(modulus);
			// zero modulus behaves as one
			if (m == 0) begin
				m = 1;
			end
			base = 64'(msg) % m;
			acc = 64'd1 % m;
			for (i = 0; i < OPERAND_BITS; i++) begin
				if (exponent[i]) begin
					acc = mul_mod(acc, base, m);
				end
				base = mul_mod(base, base, m);
			end
			return operand_t'(acc);
		endfunction

		function void note_message(operand_t msg);
			pending_powers.push_back(expected_power(msg));
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task check_power(operand_t got);
			operand_t want;
			if (pending_powers.size() == 0) begin
				report_mismatch($sformatf("power_result %0d with no item pending", got));
			end else begin
				want = pending_powers.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("power_result %0d, want %0d", got, want));
				end
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_addr;
	operand_t             cfg_wdata;
	logic                 start;
	operand_t             message_value;
	logic                 busy;
	logic                 done;
	operand_t             power_result;

	power_scoreboard power_check = new();

	modular_exponentiation_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.message_value (message_value),
		.busy          (busy),
		.done          (done),
		.power_result  (power_result)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			power_check.check_power(power_result);
		end
	end

	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
				stalled = 0;
			end else begin
				stalled++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic operand_t rand63();
		return operand_t'({$urandom(), $urandom()});
	endfunction

	function automatic operand_t pick_modulus();
		case ($urandom_range(0, 5))
			0: return operand_t'($urandom_range(0, 20));
			1: return TOP_VALUE;
			default: return rand63() >> $urandom_range(0, OPERAND_BITS - 2);
		endcase
	endfunction

	// all-ones exponent is the slowest case, keep it rare
	function automatic operand_t pick_exponent();
		case ($urandom_range(0, 7))
			0: return operand_t'($urandom_range(0, 3));
			1: return TOP_VALUE;
			default: return rand63() >> $urandom_range(0, OPERAND_BITS - 1);
		endcase
	endfunction

	function automatic operand_t pick_message(operand_t m);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return TOP_VALUE;
			2: return m - operand_t'(1);
			3: return m;
			4: return m + operand_t'(1);
			5: return rand63() >> $urandom_range(1, OPERAND_BITS - 1);
			default: return rand63();
		endcase
	endfunction

	task automatic wait_drained();
		while (power_check.pending_powers.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, operand_t value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_addr = idx;
		cfg_wdata = value;
		@(posedge clk);
		power_check.set_key(idx, value);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_addr = CFG_IDX_W'($urandom_range(0, 1));
		cfg_wdata = rand63();
	endtask

	// keys change only with nothing in flight
	task automatic load_key(operand_t m, operand_t e);
		wait_drained();
		while (busy) begin
			@(posedge clk);
		end
		write_reg(CFG_IDX_MODULUS, m);
		write_reg(CFG_IDX_EXPONENT, e);
	endtask

	task automatic send_message(operand_t v, bit calm);
		if (!calm) begin
			case ($urandom_range(0, 3))
				0: begin
					wait_drained();
					repeat ($urandom_range(1, 10)) @(negedge clk);
				end
				1: repeat ($urandom_range(1, 10)) @(negedge clk);
				default: ;
			endcase
		end
		@(negedge clk);
		start = 1'b1;
		message_value = v;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		power_check.note_message(v);
		@(negedge clk);
		start = 1'b0;
		message_value = rand63();
	endtask

	initial begin : stimulus
		int sent;
		int burst;
		int j;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_addr = CFG_IDX_MODULUS;
		cfg_wdata = '0;
		start = 1'b0;
		message_value = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset key: modulus one, exponent zero, so every result is zero
		send_message('0, 1'b0);
		send_message(TOP_VALUE, 1'b0);

		// zero modulus acts as modulus one
		load_key('0, operand_t'(5));
		send_message(operand_t'(7), 1'b0);
		send_message(TOP_VALUE, 1'b0);

		load_key(TOP_VALUE, '0);
		send_message('0, 1'b0);
		send_message(TOP_VALUE, 1'b0);

		load_key(TOP_VALUE, TOP_VALUE);
		send_message('0, 1'b1);
		send_message(operand_t'(1), 1'b1);
		send_message(operand_t'(2), 1'b0);
		send_message(TOP_VALUE - operand_t'(1), 1'b0);
		send_message(TOP_VALUE, 1'b0);

		// textbook toy key pair
		load_key(operand_t'(3233), operand_t'(17));
		send_message(operand_t'(65), 1'b0);
		send_message(operand_t'(3232), 1'b0);
		send_message(operand_t'(3233), 1'b0);
		send_message(TOP_VALUE, 1'b0);
		load_key(operand_t'(3233), operand_t'(2753));
		send_message(operand_t'(2790), 1'b0);
		send_message('0, 1'b0);

		load_key(operand_t'(2), operand_t'(1));
		send_message(operand_t'(3), 1'b0);
		send_message(TOP_VALUE - operand_t'(1), 1'b0);

		// fermat on a large prime modulus
		load_key(MERSENNE_61, MERSENNE_61 - operand_t'(1));
		send_message(operand_t'(2), 1'b0);
		send_message(rand63(), 1'b0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			load_key(pick_modulus(), pick_exponent());
			burst = $urandom_range(4, 12);
			for (j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
				send_message(pick_message(power_check.modulus),
					sent >= RANDOM_ITEMS - CALM_ITEMS);
				sent++;
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (power_check.pending_powers.size() != 0) begin
			power_check.report_mismatch($sformatf("%0d results never arrived",
				power_check.pending_powers.size()));
		end
		if (power_check.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
